// ===== hw/rtl/vinyl_noise_generator_defines.svh =====
// Assertion macros for the vinyl noise generator.
`ifndef VINYL_NOISE_GENERATOR_DEFINES_SVH
`define VINYL_NOISE_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge outside reset.
`define VNG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
    else $error("vinyl_noise_generator: assertion failed");

// Implication checked on every rising edge outside reset.
`define VNG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("vinyl_noise_generator: implication failed");

`else

`define VNG_ASSERT(lbl, clk, rst, prop)
`define VNG_ASSERT_IMP(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/vng_pkg.sv =====
// Shared types and constants for the vinyl noise generator.
`timescale 1ns / 1ps

package vng_pkg;

  typedef enum logic [2:0] {
    CFG_CRACKLE_EN = 3'd0,
    CFG_HISS_EN    = 3'd1,
    CFG_POP_PERIOD = 3'd2,
    CFG_DECAY      = 3'd3,
    CFG_FADE_STEP  = 3'd4,
    CFG_FORMAT     = 3'd5,
    CFG_SEED       = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S32 = 2'd2
  } fmt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOW,
    S_WHT,
    S_HSS,
    S_TRG,
    S_WAIT,
    S_POP,
    S_PST,
    S_DEC,
    S_DST,
    S_CRK,
    S_CST,
    S_FAD,
    S_FST,
    S_FMT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } rem_stat_t;

  // Register reset values
  localparam logic        CRACKLE_EN_RST = 1'b1;
  localparam logic        HISS_EN_RST    = 1'b1;
  localparam logic [15:0] POP_PERIOD_RST = 16'd4800;
  localparam logic [31:0] DECAY_RST      = 32'd4077000000;
  localparam logic [31:0] FADE_STEP_RST  = 32'd4473924;
  localparam logic [31:0] SEED_RST       = 32'd1;

  // Q0.32 coefficients and format scales, as multiplier operands
  localparam logic signed [33:0] K_LOW   = 34'sd107374182;
  localparam logic signed [33:0] K_POP   = 34'sd1932735283;
  localparam logic signed [33:0] K_WHITE = 34'sd51539608;
  localparam logic signed [33:0] K_HISS  = 34'sd150323855;
  localparam logic signed [33:0] K_U8    = 34'sd255;
  localparam logic signed [33:0] K_S16   = 34'sd32767;
  localparam logic signed [33:0] K_S32   = 34'sd2147483647;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  localparam logic [31:0]        POP_BASE  = 32'd268435456;
  localparam logic [32:0]        FADE_ONE  = 33'h1_0000_0000;
  localparam logic signed [35:0] LIMIT_POS = 36'sd858993459;
  localparam logic signed [35:0] LIMIT_NEG = -36'sd858993459;

endpackage

// ===== hw/rtl/vinyl_noise_generator.sv =====
// Vinyl noise generator top level: sequencer, shared multiplier and state.
`timescale 1ns / 1ps
`include "vinyl_noise_generator_defines.svh"

// One transaction on the input channel produces one PCM sample on the output
// channel. After a transaction is taken, in_stall stays high until the sequencer
// is back in idle, longer when a crackle pop fires or the output register waits
// for out_stall to drop; the run is set by the 32-step bit-serial remainder that
// tests for a pop, with all products passing through one registered 34 x 34
// multiplier in turn. A finished sample waits in the output register while the
// next transaction is accepted. Configuration is written through cfg_we,
// cfg_index and cfg_wdata; writing the seed reloads the generator at once.
module vinyl_noise_generator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_sample_bits,
  output logic              out_pop_fired,
  input  logic              cfg_we,
  input  vng_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import vng_pkg::*;

  state_t state_r, state_nxt;

  logic        crackle_en_r, crackle_en_nxt;
  logic        hiss_en_r, hiss_en_nxt;
  logic [15:0] pop_period_r, pop_period_nxt;
  logic [31:0] decay_r, decay_nxt;
  logic [31:0] fade_step_r, fade_step_nxt;
  fmt_t        format_r, format_nxt;

  logic [31:0]        noise_r, noise_nxt;
  logic signed [31:0] hiss_low_r, hiss_low_nxt;
  logic [31:0]        pop_level_r, pop_level_nxt;
  logic [32:0]        fade_r, fade_nxt;

  logic signed [30:0] white_r, white_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic signed [30:0] v_r, v_nxt;
  logic               fired_r, fired_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_bits_r, out_bits_nxt;
  logic               out_fired_r, out_fired_nxt;

  logic               mul_en;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [67:0] prod_r;

  logic               rem_start;
  rem_stat_t          rem_stat;

  logic [31:0]        xs1, xs2, xs3;
  logic signed [33:0] w34, mag34, v34;
  logic [33:0]        fade_sum;
  logic signed [35:0] r32;
  logic signed [37:0] r30;
  logic signed [36:0] r31;
  logic signed [37:0] trunc30;

  vng_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (noise_r),
    .divisor  (pop_period_r),
    .stat     (rem_stat)
  );

  assign xs1 = noise_r ^ (noise_r << 13);
  assign xs2 = xs1 ^ (xs1 >> 17);
  assign xs3 = xs2 ^ (xs2 << 5);

  assign w34      = {{3{white_r[30]}}, white_r};
  assign mag34    = white_r[30] ? -w34 : w34;
  assign v34      = {{3{v_r[30]}}, v_r};
  assign fade_sum = {1'b0, fade_r} + {2'b00, fade_step_r};

  // Round half up: floor of the shifted product plus the bit below the cut; trunc30 rounds toward zero
  assign r32     = prod_r[67:32] + {35'd0, prod_r[31]};
  assign r30     = prod_r[67:30] + {37'd0, prod_r[29]};
  assign r31     = prod_r[67:31] + {36'd0, prod_r[30]};
  assign trunc30 = prod_r[67:30] + {37'd0, prod_r[67] & (|prod_r[29:0])};

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt      = state_r;
    crackle_en_nxt = crackle_en_r;
    hiss_en_nxt    = hiss_en_r;
    pop_period_nxt = pop_period_r;
    decay_nxt      = decay_r;
    fade_step_nxt  = fade_step_r;
    format_nxt     = format_r;
    noise_nxt      = noise_r;
    hiss_low_nxt   = hiss_low_r;
    pop_level_nxt  = pop_level_r;
    fade_nxt       = fade_r;
    white_nxt      = white_r;
    acc_nxt        = acc_r;
    v_nxt          = v_r;
    fired_nxt      = fired_r;
    out_valid_nxt  = out_valid_r;
    out_bits_nxt   = out_bits_r;
    out_fired_nxt  = out_fired_r;
    mul_en         = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    rem_start      = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_CRACKLE_EN: crackle_en_nxt = cfg_wdata[0];
        CFG_HISS_EN:    hiss_en_nxt    = cfg_wdata[0];
        CFG_POP_PERIOD: pop_period_nxt = cfg_wdata[15:0];
        CFG_DECAY:      decay_nxt      = cfg_wdata;
        CFG_FADE_STEP:  fade_step_nxt  = cfg_wdata;
        CFG_FORMAT:     format_nxt     = fmt_t'(cfg_wdata[1:0]);
        CFG_SEED:       noise_nxt      = (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          noise_nxt = xs3;
          white_nxt = {~xs3[31], xs3[30:1]};
          acc_nxt   = '0;
          fired_nxt = 1'b0;
          if (in_restart) begin
            hiss_low_nxt  = '0;
            pop_level_nxt = '0;
            fade_nxt      = '0;
          end
          state_nxt = S_LOW;
        end
      end
      S_LOW: begin
        mul_en    = 1'b1;
        mul_a     = w34 - {{2{hiss_low_r[31]}}, hiss_low_r};
        mul_b     = K_LOW;
        rem_start = 1'b1;
        fade_nxt  = (fade_sum > {1'b0, FADE_ONE}) ? FADE_ONE : fade_sum[32:0];
        state_nxt = S_WHT;
      end
      S_WHT: begin
        hiss_low_nxt = hiss_low_r + r32[31:0];
        mul_en       = 1'b1;
        mul_a        = w34;
        mul_b        = K_WHITE;
        state_nxt    = S_HSS;
      end
      S_HSS: begin
        if (hiss_en_r) begin
          acc_nxt = acc_r + r32[33:0];
        end
        mul_en    = 1'b1;
        mul_a     = {{2{hiss_low_r[31]}}, hiss_low_r};
        mul_b     = K_HISS;
        state_nxt = S_TRG;
      end
      S_TRG: begin
        if (hiss_en_r) begin
          acc_nxt = acc_r + r32[33:0];
        end
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!rem_stat.busy) begin
          state_nxt = (crackle_en_r && rem_stat.zero) ? S_POP : S_DEC;
        end
      end
      S_POP: begin
        mul_en    = 1'b1;
        mul_a     = mag34;
        mul_b     = K_POP;
        fired_nxt = 1'b1;
        state_nxt = S_PST;
      end
      S_PST: begin
        pop_level_nxt = POP_BASE + r32[31:0];
        state_nxt     = S_DEC;
      end
      S_DEC: begin
        mul_en    = 1'b1;
        mul_a     = {2'b00, pop_level_r};
        mul_b     = {2'b00, decay_r};
        state_nxt = S_DST;
      end
      S_DST: begin
        pop_level_nxt = r32[31:0];
        state_nxt     = S_CRK;
      end
      S_CRK: begin
        mul_en    = 1'b1;
        mul_a     = {2'b00, pop_level_r};
        mul_b     = w34;
        state_nxt = S_CST;
      end
      S_CST: begin
        if (crackle_en_r) begin
          acc_nxt = acc_r + r30[33:0];
        end
        state_nxt = S_FAD;
      end
      S_FAD: begin
        mul_en    = 1'b1;
        mul_a     = acc_r;
        mul_b     = {1'b0, fade_r};
        state_nxt = S_FST;
      end
      S_FST: begin
        if (r32 > LIMIT_POS) begin
          v_nxt = LIMIT_POS[30:0];
        end else if (r32 < LIMIT_NEG) begin
          v_nxt = LIMIT_NEG[30:0];
        end else begin
          v_nxt = r32[30:0];
        end
        state_nxt = S_FMT;
      end
      S_FMT: begin
        mul_en = 1'b1;
        case (format_r)
          FMT_U8: begin
            mul_a = v34 + ONE_Q30;
            mul_b = K_U8;
          end
          FMT_S16: begin
            mul_a = v34;
            mul_b = K_S16;
          end
          default: begin
            mul_a = v34;
            mul_b = K_S32;
          end
        endcase
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = fired_r;
          case (format_r)
            FMT_U8:  out_bits_nxt = {24'd0, r31[7:0]};
            FMT_S16: out_bits_nxt = {16'd0, r30[15:0]};
            FMT_S32: out_bits_nxt = trunc30[31:0];
            default: out_bits_nxt = '0;
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      crackle_en_r <= CRACKLE_EN_RST;
      hiss_en_r    <= HISS_EN_RST;
      pop_period_r <= POP_PERIOD_RST;
      decay_r      <= DECAY_RST;
      fade_step_r  <= FADE_STEP_RST;
      format_r     <= FMT_S16;
      noise_r      <= SEED_RST;
      hiss_low_r   <= '0;
      pop_level_r  <= '0;
      fade_r       <= '0;
      fired_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      crackle_en_r <= crackle_en_nxt;
      hiss_en_r    <= hiss_en_nxt;
      pop_period_r <= pop_period_nxt;
      decay_r      <= decay_nxt;
      fade_step_r  <= fade_step_nxt;
      format_r     <= format_nxt;
      noise_r      <= noise_nxt;
      hiss_low_r   <= hiss_low_nxt;
      pop_level_r  <= pop_level_nxt;
      fade_r       <= fade_nxt;
      fired_r      <= fired_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    white_r     <= white_nxt;
    acc_r       <= acc_nxt;
    v_r         <= v_nxt;
    out_bits_r  <= out_bits_nxt;
    out_fired_r <= out_fired_nxt;
    if (mul_en) begin
      prod_r <= mul_p;
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_sample_bits = out_bits_r;
  assign out_pop_fired   = out_fired_r;

  `VNG_ASSERT_IMP(a_accept_starts_seq, clk, rst_n, in_valid && !in_stall, ##1 state_r == S_LOW)
  `VNG_ASSERT_IMP(a_out_from_seq, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_OUT)
  `VNG_ASSERT(a_fade_saturates, clk, rst_n, fade_r <= FADE_ONE)

endmodule

// ===== hw/rtl/vng_rem.sv =====
// Bit-serial remainder of a 32-bit word by a 16-bit period.
`timescale 1ns / 1ps

module vng_rem (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       dividend,
  input  logic [15:0]       divisor,
  output vng_pkg::rem_stat_t stat
);
  import vng_pkg::*;

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [15:0] r_r, r_nxt;
  logic [15:0] d_r, d_nxt;
  logic [16:0] shifted;
  logic [16:0] diff;

  assign shifted = {r_r, q_r[31]};
  assign diff    = shifted - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = (divisor == 16'd0) ? 16'd1 : divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[30:0], 1'b0};
      r_nxt   = diff[16] ? shifted[15:0] : diff[15:0];
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.zero = (r_r == 16'd0);

endmodule

// ===== dv/tb_vinyl_noise_generator.sv =====
// Self-checking testbench for vinyl_noise_generator against a fixed-point sample predictor.
`timescale 1ns / 1ps

module tb_vinyl_noise_generator;
  import vng_pkg::*;

  localparam int unsigned RANDOM_TICKS = 750;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint FADE_UNITY  = 64'sd4294967296;
  localparam longint POP_FLOOR   = 64'sd268435456;
  localparam longint CLAMP_Q30   = 64'sd858993459;
  localparam longint C_LOWPASS   = 64'sd107374182;
  localparam longint C_POP_GAIN  = 64'sd1932735283;
  localparam longint C_WHITE_MIX = 64'sd51539608;
  localparam longint C_HISS_MIX  = 64'sd150323855;

  typedef struct packed {
    logic [31:0] bits;
    logic        fired;
  } pcm_word_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_restart = 1'b0;
  logic        out_stall  = 1'b0;
  logic        cfg_we     = 1'b0;
  cfg_idx_t    cfg_index  = CFG_CRACKLE_EN;
  logic [31:0] cfg_wdata  = 32'd0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_sample_bits;
  logic        out_pop_fired;

  // Predictor copy of registers and state
  logic        crackle_on = 1'b1;
  logic        hiss_on    = 1'b1;
  logic [15:0] pop_span   = 16'd4800;
  logic [31:0] decay_k    = 32'd4077000000;
  logic [31:0] fade_inc   = 32'd4473924;
  logic [1:0]  pcm_fmt    = FMT_S16;
  logic [31:0] rng_word   = 32'd1;
  int          hiss_lp    = 0;
  logic [31:0] pop_env    = 32'd0;
  longint      fade_lvl   = 0;

  pcm_word_t   pcm_expected[$];
  pcm_word_t   pcm_want;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_left     = 0;
  logic [1:0]  stall_mode     = 2'd0;

  vinyl_noise_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_bits (out_sample_bits),
    .out_pop_fired   (out_pop_fired),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint rnd_shift(input longint v, input int unsigned s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic pcm_word_t next_sample(input logic restart);
    logic [31:0] x;
    logic [31:0] span;
    logic [63:0] env;
    longint      white, mag, mix, v, pcm;
    pcm_word_t   res;
    res = '0;
    if (restart) begin
      hiss_lp  = 0;
      pop_env  = 32'd0;
      fade_lvl = 0;
    end
    x = rng_word;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rng_word = x;
    white = longint'({32'd0, x >> 1}) - Q30_ONE;
    hiss_lp = int'(longint'(hiss_lp)
                   + rnd_shift((white - longint'(hiss_lp)) * C_LOWPASS, 32));
    span = (pop_span == 16'd0) ? 32'd1 : {16'd0, pop_span};
    if (crackle_on && (x % span) == 32'd0) begin
      mag = (white < 0) ? -white : white;
      pop_env = 32'(POP_FLOOR + rnd_shift(mag * C_POP_GAIN, 32));
      res.fired = 1'b1;
    end
    env = {32'd0, pop_env} * {32'd0, decay_k} + 64'h8000_0000;
    pop_env = env[63:32];
    fade_lvl = fade_lvl + longint'({32'd0, fade_inc});
    if (fade_lvl > FADE_UNITY) fade_lvl = FADE_UNITY;
    mix = 0;
    if (crackle_on) mix += rnd_shift(longint'({32'd0, pop_env}) * white, 30);
    if (hiss_on) begin
      mix += rnd_shift(white * C_WHITE_MIX, 32) + rnd_shift(longint'(hiss_lp) * C_HISS_MIX, 32);
    end
    v = rnd_shift(mix * fade_lvl, 32);
    if (v > CLAMP_Q30) v = CLAMP_Q30;
    if (v < -CLAMP_Q30) v = -CLAMP_Q30;
    case (pcm_fmt)
      FMT_U8: begin
        pcm = ((v + Q30_ONE) * 255 + Q30_ONE) >>> 31;
        res.bits = {24'd0, pcm[7:0]};
      end
      FMT_S16: begin
        pcm = rnd_shift(v * 32767, 30);
        res.bits = {16'd0, pcm[15:0]};
      end
      FMT_S32: begin
        mag = (v < 0) ? -v : v;
        pcm = (mag * 64'sd2147483647) >>> 30;
        if (v < 0) pcm = -pcm;
        res.bits = pcm[31:0];
      end
      default: res.bits = 32'd0;
    endcase
    return res;
  endfunction

  function automatic void load_reg(input cfg_idx_t idx, input logic [31:0] data);
    case (idx)
      CFG_CRACKLE_EN: crackle_on = data[0];
      CFG_HISS_EN:    hiss_on    = data[0];
      CFG_POP_PERIOD: pop_span   = data[15:0];
      CFG_DECAY:      decay_k    = data;
      CFG_FADE_STEP:  fade_inc   = data;
      CFG_FORMAT:     pcm_fmt    = data[1:0];
      CFG_SEED:       rng_word   = (data == 32'd0) ? 32'd1 : data;
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
  endtask

  // Every call starts right after a rising edge
  task automatic send_tick(input logic restart);
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pcm_expected.push_back(next_sample(restart));
  endtask

  task automatic send_seq(input logic [31:0] restarts, input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) send_tick(restarts[k]);
    in_valid <= 1'b0;
  endtask

  task automatic run_ticks(input int unsigned n, input int unsigned restart_pct);
    int unsigned k, burst;
    burst = $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      send_tick($urandom_range(0, 99) < restart_pct);
      burst--;
      if (burst == 0 && k + 1 < n) begin
        in_valid   <= 1'b0;
        in_restart <= 1'($urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(9, 60)) @(posedge clk);
        else repeat ($urandom_range(1, 8)) @(posedge clk);
        burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pcm_expected.size() != 0 || in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    load_reg(idx, data);
  endtask

  // Unused upper bits of the narrow registers carry random junk
  task automatic set_regs(input logic ce, input logic he, input logic [15:0] span,
                          input logic [31:0] dk, input logic [31:0] fi,
                          input logic [1:0] fm, input logic ld, input logic [31:0] sd);
    settle();
    write_reg(CFG_CRACKLE_EN, ($urandom() & 32'hFFFF_FFFE) | {31'd0, ce});
    write_reg(CFG_HISS_EN, ($urandom() & 32'hFFFF_FFFE) | {31'd0, he});
    write_reg(CFG_POP_PERIOD, ($urandom() & 32'hFFFF_0000) | {16'd0, span});
    write_reg(CFG_DECAY, dk);
    write_reg(CFG_FADE_STEP, fi);
    write_reg(CFG_FORMAT, ($urandom() & 32'hFFFF_FFFC) | {30'd0, fm});
    if (ld) write_reg(CFG_SEED, sd);
    cfg_we <= 1'b0;
  endtask

  task automatic test_power_on_defaults();
    send_seq(32'b00100, 5);
  endtask

  task automatic test_output_formats();
    int f;
    for (f = 0; f < 4; f++) begin
      set_regs(1'b1, 1'b1, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, f[1:0], f == 0,
               32'hFFFF_FFFF);
      send_seq(32'b001, 3);
    end
  endtask

  task automatic test_corner_registers();
    // zero period and zero seed
    set_regs(1'b1, 1'b1, 16'd0, 32'd0, 32'hFFFF_FFFF, FMT_S32, 1'b1, 32'd0);
    send_seq(32'b001, 3);
    // no fade, crackle off
    set_regs(1'b0, 1'b1, 16'd3, 32'd4077000000, 32'd0, FMT_S16, 1'b0, 32'd0);
    send_seq(32'b01, 2);
    set_regs(1'b1, 1'b0, 16'hFFFF, 32'h8000_0000, 32'h1000_0000, FMT_U8, 1'b1, 32'd1);
    send_seq(32'b01, 2);
  endtask

  task automatic test_random_phases();
    int unsigned sent, chunk;
    logic        ce, he, ld;
    logic [15:0] span;
    logic [31:0] dk, fi, sd;
    logic [1:0]  fm;
    int unsigned pick;
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      ce = ($urandom_range(0, 3) != 0);
      he = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: span = 16'($urandom_range(1, 4));
        1: span = 16'($urandom_range(5, 40));
        2: span = 16'($urandom_range(41, 1000));
        3: span = 16'($urandom_range(0, 65535));
        4: span = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
        default: span = 16'd4800;
      endcase
      case ($urandom_range(0, 3))
        0: dk = 32'd0;
        1: dk = 32'hFFFF_FFFF;
        2: dk = $urandom();
        default: dk = $urandom_range(32'd3500000000, 32'hFFFF_FFFF);
      endcase
      case ($urandom_range(0, 4))
        0: fi = 32'd0;
        1: fi = 32'hFFFF_FFFF;
        2: fi = $urandom();
        3: fi = $urandom_range(1, 50000000);
        default: fi = 32'd4473924;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 3) fm = FMT_U8;
      else if (pick < 6) fm = FMT_S16;
      else if (pick < 9) fm = FMT_S32;
      else fm = 2'd3;
      ld = $urandom_range(0, 1);
      pick = $urandom_range(0, 9);
      sd = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
      set_regs(ce, he, span, dk, fi, fm, ld, sd);
      chunk = $urandom_range(20, 70);
      run_ticks(chunk, 6);
      sent += chunk;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_on_defaults();
    test_output_formats();
    test_corner_registers();
    test_random_phases();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pcm_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= 1'($urandom_range(0, 1));
      2'd2: out_stall <= ($urandom_range(0, 7) == 0);
      default: out_stall <= (stall_left[5:4] == 2'b11);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pcm_expected.size() == 0) begin
        flag_mismatch("sample with none pending", 32'd0, out_sample_bits);
      end else begin
        pcm_want = pcm_expected.pop_front();
        if (out_sample_bits !== pcm_want.bits)
          flag_mismatch("sample_bits", pcm_want.bits, out_sample_bits);
        if (out_pop_fired !== pcm_want.fired)
          flag_mismatch("pop_fired", {31'd0, pcm_want.fired}, {31'd0, out_pop_fired});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ===== vinyl_noise_generator.f =====
+incdir+hw/rtl
hw/rtl/vng_pkg.sv
hw/rtl/vng_rem.sv
hw/rtl/vinyl_noise_generator.sv
dv/tb_vinyl_noise_generator.sv
